// ----- rtl/core/polygon_plane_clipper_macros.svh -----
// assertion macros for the polygon plane clipper
`ifndef POLYGON_PLANE_CLIPPER_MACROS_SVH
`define POLYGON_PLANE_CLIPPER_MACROS_SVH

// condition must hold in the same cycle
`define PPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polygon_plane_clipper: same-cycle check failed");

// condition must hold in the following cycle
`define PPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("polygon_plane_clipper: next-cycle check failed");

`endif

// ----- rtl/core/ppc_pkg.sv -----
// shared types and constants for the polygon plane clipper
`default_nettype none

package ppc_pkg;

  // field widths
  localparam int COORD_W    = 32;
  localparam int NORM_W     = 16;
  localparam int OFFSET_W   = 32;
  localparam int TOTAL_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // vertex components
  localparam int NUM_COMP   = 5;
  localparam int COMP_IDX_W = 3;
  localparam logic [COMP_IDX_W-1:0] COMP_X    = 3'd0;
  localparam logic [COMP_IDX_W-1:0] COMP_Y    = 3'd1;
  localparam logic [COMP_IDX_W-1:0] COMP_Z    = 3'd2;
  localparam logic [COMP_IDX_W-1:0] COMP_LAST = 3'd4;

  // arithmetic widths
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 33;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W;
  localparam int NORM_SHIFT = 14;
  localparam int DIST_W     = 40;
  localparam int MAG_W      = DIST_W + 1;
  localparam int FRAC_W     = 16;
  localparam int DIV_CNT_W  = 5;

  // defaults
  localparam int MAX_VERTS_DEF = 32;
  localparam logic signed [NORM_W-1:0] NORM_X_RST = 16'sd0;
  localparam logic signed [NORM_W-1:0] NORM_Y_RST = 16'sd0;
  localparam logic signed [NORM_W-1:0] NORM_Z_RST = 16'sd16384;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 32'sd0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t vert_t [NUM_COMP];

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X = 2'd0,
    CFG_NORMAL_Y = 2'd1,
    CFG_NORMAL_Z = 2'd2,
    CFG_OFFSET   = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIST,
    ST_SETUP,
    ST_EDGE,
    ST_DIV,
    ST_IDEL,
    ST_IMUL,
    ST_IADD,
    ST_EMIT_X,
    ST_EMIT_V,
    ST_EMIT_E
  } state_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // one result transaction
  typedef struct packed {
    coord_t             x;
    coord_t             y;
    coord_t             z;
    coord_t             s;
    coord_t             t;
    logic               holds_vertex;
    logic               polygon_done;
    logic [TOTAL_W-1:0] vertex_total;
    logic               too_many;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppc_mul.sv -----
// shared signed multiplier with registered product
`default_nettype none

module ppc_mul (
  input  wire logic                               clk,
  input  wire logic signed [ppc_pkg::MUL_A_W-1:0] op_a,
  input  wire logic signed [ppc_pkg::MUL_B_W-1:0] op_b,
  output logic signed [ppc_pkg::PROD_W-1:0]       prod
);

  // product register, no reset needed
  always_ff @(posedge clk) begin
    prod <= ppc_pkg::PROD_W'(op_a * op_b);
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppc_div.sv -----
// serial restoring divider for the crossing fraction, one quotient bit per cycle
`default_nettype none

module ppc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ppc_pkg::MAG_W-1:0]   num,
  input  wire logic [ppc_pkg::MAG_W-1:0]   den,
  output ppc_pkg::div_stat_t               stat,
  output logic [ppc_pkg::FRAC_W-1:0]       quo
);

  logic [ppc_pkg::MAG_W-1:0]     rem;
  logic [ppc_pkg::MAG_W-1:0]     den_r;
  logic [ppc_pkg::DIV_CNT_W-1:0] cnt;
  logic                          done_r;
  logic [ppc_pkg::MAG_W:0]       rem2;
  logic                          ge;

  // shift remainder and trial compare
  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  // step counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt    <= ppc_pkg::DIV_CNT_W'(ppc_pkg::FRAC_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt == ppc_pkg::DIV_CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - ppc_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // remainder and quotient, numerator is below denominator so rem stays below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quo   <= '0;
    end else if (cnt != '0) begin
      if (ge) begin
        rem <= ppc_pkg::MAG_W'(rem2 - {1'b0, den_r});
      end else begin
        rem <= rem2[ppc_pkg::MAG_W-1:0];
      end
      quo <= {quo[ppc_pkg::FRAC_W-2:0], ge};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ----- rtl/core/ppc_outreg.sv -----
// output register holding one result transaction until taken
`default_nettype none

module ppc_outreg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire ppc_pkg::result_t  din,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output ppc_pkg::result_t       dout,
  output logic                   free
);

  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/polygon_plane_clipper.sv -----
// Single-plane polygon clipper: takes one vertex transaction at a time and is not
// ready while it works on it. A vertex passes through three distance multiplies and
// three accumulates through the shared multiplier, then distance, setup, edge check
// and the vertex emit; the first vertex of a polygon has no incoming edge and skips
// the edge check. Each edge that crosses the plane adds the 16-step serial divider
// for the fraction and the wait for its done flag, a delta, multiply and add step per
// component for the five interpolations through the same multiplier, and the emit.
// The closing vertex also runs the closing edge and emits the end marker. Each result
// waits in the output register until taken, so a stalled consumer holds up the
// sequencer in its emit states.
`default_nettype none

module polygon_plane_clipper #(
  parameter int MAX_VERTS = ppc_pkg::MAX_VERTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [ppc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // vertex input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [ppc_pkg::COORD_W-1:0]  vert_x,
  input  wire logic signed [ppc_pkg::COORD_W-1:0]  vert_y,
  input  wire logic signed [ppc_pkg::COORD_W-1:0]  vert_z,
  input  wire logic signed [ppc_pkg::COORD_W-1:0]  vert_s,
  input  wire logic signed [ppc_pkg::COORD_W-1:0]  vert_t,
  input  wire logic                                closing_vertex,
  // result output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [ppc_pkg::COORD_W-1:0]       out_x,
  output logic signed [ppc_pkg::COORD_W-1:0]       out_y,
  output logic signed [ppc_pkg::COORD_W-1:0]       out_z,
  output logic signed [ppc_pkg::COORD_W-1:0]       out_s,
  output logic signed [ppc_pkg::COORD_W-1:0]       out_t,
  output logic                                     holds_vertex,
  output logic                                     polygon_done,
  output logic [ppc_pkg::TOTAL_W-1:0]              vertex_total,
  output logic                                     too_many
);

  `include "polygon_plane_clipper_macros.svh"

  localparam int CNT_W = $clog2(MAX_VERTS + 1);

  // configuration registers
  logic signed [ppc_pkg::NORM_W-1:0]   plane_normal_x;
  logic signed [ppc_pkg::NORM_W-1:0]   plane_normal_y;
  logic signed [ppc_pkg::NORM_W-1:0]   plane_normal_z;
  logic signed [ppc_pkg::OFFSET_W-1:0] plane_offset;

  // sequencer
  ppc_pkg::state_t state;
  ppc_pkg::state_t state_next;
  logic [ppc_pkg::COMP_IDX_W-1:0] idx;
  logic phase;
  logic closing_r;

  // vertex and distance storage
  ppc_pkg::vert_t cur_v;
  ppc_pkg::vert_t first_v;
  ppc_pkg::vert_t prior_v;
  ppc_pkg::vert_t res_v;
  logic signed [ppc_pkg::DIST_W-1:0] d_cur;
  logic signed [ppc_pkg::DIST_W-1:0] first_d;
  logic signed [ppc_pkg::DIST_W-1:0] prior_d;
  logic have_first;
  logic [CNT_W-1:0] count;

  // arithmetic
  logic signed [ppc_pkg::ACC_W-1:0]   acc;
  logic signed [ppc_pkg::MUL_B_W-1:0] delta_r;
  logic signed [ppc_pkg::MUL_A_W-1:0] op_a;
  logic signed [ppc_pkg::MUL_B_W-1:0] op_b;
  logic signed [ppc_pkg::PROD_W-1:0]  prod;
  logic signed [ppc_pkg::PROD_W-1:0]  prod_shr;
  logic signed [ppc_pkg::NORM_W-1:0]  norm_sel;

  // edge operands
  logic signed [ppc_pkg::DIST_W-1:0] d0;
  logic signed [ppc_pkg::DIST_W-1:0] d1;
  logic signed [ppc_pkg::MAG_W-1:0]  d0_ext;
  logic signed [ppc_pkg::MAG_W-1:0]  d1_ext;
  logic [ppc_pkg::MAG_W-1:0]         d0_mag;
  logic [ppc_pkg::MAG_W-1:0]         d1_mag;
  logic [ppc_pkg::MAG_W-1:0]         den;
  ppc_pkg::coord_t                   v0_sel;
  ppc_pkg::coord_t                   v1_sel;
  logic                              is_cross;
  logic                              full;

  // divider
  logic                          div_start;
  ppc_pkg::div_stat_t            div_stat;
  logic [ppc_pkg::FRAC_W-1:0]    frac;

  // output register
  logic             out_load;
  logic             slot_free;
  ppc_pkg::result_t out_din;
  ppc_pkg::result_t out_dout;
  ppc_pkg::state_t  after_edge;
  ppc_pkg::state_t  after_vertex;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_normal_x <= ppc_pkg::NORM_X_RST;
      plane_normal_y <= ppc_pkg::NORM_Y_RST;
      plane_normal_z <= ppc_pkg::NORM_Z_RST;
      plane_offset   <= ppc_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      unique case (ppc_pkg::cfg_reg_t'(cfg_index))
        ppc_pkg::CFG_NORMAL_X: plane_normal_x <= cfg_data[ppc_pkg::NORM_W-1:0];
        ppc_pkg::CFG_NORMAL_Y: plane_normal_y <= cfg_data[ppc_pkg::NORM_W-1:0];
        ppc_pkg::CFG_NORMAL_Z: plane_normal_z <= cfg_data[ppc_pkg::NORM_W-1:0];
        ppc_pkg::CFG_OFFSET:   plane_offset   <= cfg_data[ppc_pkg::OFFSET_W-1:0];
      endcase
    end
  end

  // edge endpoints: prior to current, or current back to first
  assign v0_sel = phase ? cur_v[idx]   : prior_v[idx];
  assign v1_sel = phase ? first_v[idx] : cur_v[idx];
  assign d0     = phase ? d_cur   : prior_d;
  assign d1     = phase ? first_d : d_cur;

  // crossing test and divider operands
  assign is_cross = (d0 != '0) && (d1 != '0) &&
                    (d0[ppc_pkg::DIST_W-1] != d1[ppc_pkg::DIST_W-1]);
  assign d0_ext = ppc_pkg::MAG_W'(d0);
  assign d1_ext = ppc_pkg::MAG_W'(d1);
  assign d0_mag = d0[ppc_pkg::DIST_W-1] ? ppc_pkg::MAG_W'(-d0_ext) : ppc_pkg::MAG_W'(d0_ext);
  assign d1_mag = d1[ppc_pkg::DIST_W-1] ? ppc_pkg::MAG_W'(-d1_ext) : ppc_pkg::MAG_W'(d1_ext);
  assign den    = d0_mag + d1_mag;

  assign full = (count >= CNT_W'(MAX_VERTS));

  // normal component for the distance dot product
  always_comb begin
    unique case (idx)
      ppc_pkg::COMP_X: norm_sel = plane_normal_x;
      ppc_pkg::COMP_Y: norm_sel = plane_normal_y;
      ppc_pkg::COMP_Z: norm_sel = plane_normal_z;
      default:         norm_sel = plane_normal_z;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    if (state == ppc_pkg::ST_MUL) begin
      op_a = ppc_pkg::MUL_A_W'(norm_sel);
      op_b = ppc_pkg::MUL_B_W'(cur_v[idx]);
    end else begin
      op_a = $signed({1'b0, frac});
      op_b = delta_r;
    end
  end

  ppc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign prod_shr = prod >>> ppc_pkg::FRAC_W;

  ppc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (d0_mag),
    .den   (den),
    .stat  (div_stat),
    .quo   (frac)
  );

  // where to go after an edge and after the current vertex
  assign after_edge   = phase ? ppc_pkg::ST_EMIT_E : ppc_pkg::ST_EMIT_V;
  assign after_vertex = closing_r ? ppc_pkg::ST_EDGE : ppc_pkg::ST_IDLE;

  // next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_din    = '0;
    unique case (state)
      ppc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ppc_pkg::ST_MUL;
        end
      end
      ppc_pkg::ST_MUL: state_next = ppc_pkg::ST_ACC;
      ppc_pkg::ST_ACC: begin
        state_next = (idx == ppc_pkg::COMP_Z) ? ppc_pkg::ST_DIST : ppc_pkg::ST_MUL;
      end
      ppc_pkg::ST_DIST: state_next = ppc_pkg::ST_SETUP;
      ppc_pkg::ST_SETUP: begin
        state_next = have_first ? ppc_pkg::ST_EDGE : ppc_pkg::ST_EMIT_V;
      end
      ppc_pkg::ST_EDGE: begin
        if (is_cross) begin
          div_start  = 1'b1;
          state_next = ppc_pkg::ST_DIV;
        end else begin
          state_next = after_edge;
        end
      end
      ppc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = ppc_pkg::ST_IDEL;
        end
      end
      ppc_pkg::ST_IDEL: state_next = ppc_pkg::ST_IMUL;
      ppc_pkg::ST_IMUL: state_next = ppc_pkg::ST_IADD;
      ppc_pkg::ST_IADD: begin
        state_next = (idx == ppc_pkg::COMP_LAST) ? ppc_pkg::ST_EMIT_X : ppc_pkg::ST_IDEL;
      end
      ppc_pkg::ST_EMIT_X: begin
        out_din.x            = res_v[0];
        out_din.y            = res_v[1];
        out_din.z            = res_v[2];
        out_din.s            = res_v[3];
        out_din.t            = res_v[4];
        out_din.holds_vertex = 1'b1;
        if (full) begin
          state_next = after_edge;
        end else if (slot_free) begin
          out_load   = 1'b1;
          state_next = after_edge;
        end
      end
      ppc_pkg::ST_EMIT_V: begin
        out_din.x            = cur_v[0];
        out_din.y            = cur_v[1];
        out_din.z            = cur_v[2];
        out_din.s            = cur_v[3];
        out_din.t            = cur_v[4];
        out_din.holds_vertex = 1'b1;
        if (d_cur[ppc_pkg::DIST_W-1] || full) begin
          state_next = after_vertex;
        end else if (slot_free) begin
          out_load   = 1'b1;
          state_next = after_vertex;
        end
      end
      ppc_pkg::ST_EMIT_E: begin
        out_din.polygon_done = 1'b1;
        out_din.vertex_total = ppc_pkg::TOTAL_W'(count);
        out_din.too_many     = full;
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ppc_pkg::ST_IDLE;
        end
      end
      default: state_next = ppc_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control counters and polygon bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      phase      <= 1'b0;
      have_first <= 1'b0;
      count      <= '0;
    end else begin
      unique case (state)
        ppc_pkg::ST_IDLE: begin
          idx   <= '0;
          phase <= 1'b0;
        end
        ppc_pkg::ST_ACC: begin
          idx <= (idx == ppc_pkg::COMP_Z) ? '0 : idx + ppc_pkg::COMP_IDX_W'(1);
        end
        ppc_pkg::ST_SETUP: begin
          if (!have_first) begin
            have_first <= 1'b1;
            count      <= '0;
          end
        end
        ppc_pkg::ST_EDGE: idx <= '0;
        ppc_pkg::ST_IADD: begin
          idx <= (idx == ppc_pkg::COMP_LAST) ? '0 : idx + ppc_pkg::COMP_IDX_W'(1);
        end
        ppc_pkg::ST_EMIT_X: begin
          if (out_load) begin
            count <= count + CNT_W'(1);
          end
        end
        ppc_pkg::ST_EMIT_V: begin
          if (out_load) begin
            count <= count + CNT_W'(1);
          end
          if (state_next != ppc_pkg::ST_EMIT_V) begin
            phase <= 1'b1;
          end
        end
        ppc_pkg::ST_EMIT_E: begin
          if (out_load) begin
            have_first <= 1'b0;
            count      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ppc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_v[0]  <= vert_x;
          cur_v[1]  <= vert_y;
          cur_v[2]  <= vert_z;
          cur_v[3]  <= vert_s;
          cur_v[4]  <= vert_t;
          closing_r <= closing_vertex;
        end
      end
      ppc_pkg::ST_ACC: begin
        acc <= (idx == ppc_pkg::COMP_X) ? prod : acc + prod;
      end
      ppc_pkg::ST_DIST: begin
        d_cur <= ppc_pkg::DIST_W'(acc >>> ppc_pkg::NORM_SHIFT) -
                 ppc_pkg::DIST_W'(plane_offset);
      end
      ppc_pkg::ST_SETUP: begin
        if (!have_first) begin
          first_v <= cur_v;
          first_d <= d_cur;
        end
      end
      ppc_pkg::ST_IDEL: begin
        delta_r <= ppc_pkg::MUL_B_W'(v1_sel) - ppc_pkg::MUL_B_W'(v0_sel);
      end
      ppc_pkg::ST_IADD: begin
        res_v[idx] <= v0_sel + prod_shr[ppc_pkg::COORD_W-1:0];
      end
      ppc_pkg::ST_EMIT_V: begin
        if (state_next != ppc_pkg::ST_EMIT_V) begin
          prior_v <= cur_v;
          prior_d <= d_cur;
        end
      end
      default: ;
    endcase
  end

  ppc_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .din       (out_din),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dout      (out_dout),
    .free      (slot_free)
  );

  assign out_x        = out_dout.x;
  assign out_y        = out_dout.y;
  assign out_z        = out_dout.z;
  assign out_s        = out_dout.s;
  assign out_t        = out_dout.t;
  assign holds_vertex = out_dout.holds_vertex;
  assign polygon_done = out_dout.polygon_done;
  assign vertex_total = out_dout.vertex_total;
  assign too_many     = out_dout.too_many;

  // checks on the sequencer
  `PPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `PPC_ASSERT_SAME(a_div_done_in_div, div_stat.done, state == ppc_pkg::ST_DIV)
  `PPC_ASSERT_NEXT(a_marker_loaded, state == ppc_pkg::ST_EMIT_E && slot_free,
                   out_valid && polygon_done && !holds_vertex)

endmodule

`default_nettype wire
